FILE: sv/fssg_pkg.sv
// shared types, constants and codes for the frame sample sound generator
`default_nettype none

package fssg_pkg;

  // defaults of the top level parameters
  localparam int FRAME_SAMPLES_DEF     = 370;
  localparam int CLOCKS_PER_SAMPLE_DEF = 352;
  localparam int SILENCE_LIMIT_DEF     = 60;
  localparam int FRAME_START_INDEX_DEF = 16;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 9;
  localparam int VOL_W     = 3;
  localparam int DIVISOR_W = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  localparam logic [SAMPLE_W-1:0] MIDPOINT  = 16'h8000;
  localparam logic [BYTE_W-1:0]   BYTE_MID  = 8'h80;
  localparam logic [DIVISOR_W-1:0] DIV_BASE = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 4'd1;

  // request opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FRAME = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_MID_FILL,
    ST_FRAME_END,
    ST_FRAME_RD
  } state_t;

  // input request payload
  typedef struct packed {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] cycle_count;
    logic [IDX_W-1:0] slot_index;
    logic [BYTE_W-1:0] slot_byte;
    logic [IDX_W-1:0] frame_index;
  } fssg_in_t;

  // result payload
  typedef struct packed {
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample_value;
    logic                frame_play;
    logic                speaker_start;
    logic                speaker_stop;
    logic [IDX_W-1:0]    frame_length;
    logic [SAMPLE_W-1:0] read_data;
  } fssg_out_t;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [SAMPLE_W-1:0]  dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/fssg_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fssg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/fssg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module fssg_div import fssg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(SAMPLE_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [SAMPLE_W-1:0]  quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] div_r, div_nxt;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // one shift, compare and subtract step
  always_comb begin
    trial    = {rem_r, quo_r[SAMPLE_W-1]};
    fits     = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, div_r}) : DIVISOR_W'(trial);
      quo_nxt = {quo_r[SAMPLE_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SAMPLE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

FILE: sv/frame_sample_sound_generator_top.sv
// frame sample sound generator: sequencer, buffer shadow, frame store and divider
// a sampling tick waits on the 16-step serial divider; a frame end with sound enabled runs
// the divider once per missing sample, and with sound disabled writes one midpoint per entry
// one request at a time, busy high meanwhile; the receiver cannot stall results
// reset: synchronous, then a clearing pass that writes zero to every slot ram entry
`default_nettype none

module frame_sample_sound_generator_top import fssg_pkg::*; #(
  parameter int FRAME_SAMPLES     = FRAME_SAMPLES_DEF,
  parameter int CLOCKS_PER_SAMPLE = CLOCKS_PER_SAMPLE_DEF,
  parameter int SILENCE_LIMIT     = SILENCE_LIMIT_DEF,
  parameter int FRAME_START_INDEX = FRAME_START_INDEX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire fssg_in_t             in_data,
  output logic                      out_strobe,
  output fssg_out_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = $clog2(FRAME_SAMPLES);
  localparam int FW = $clog2(FRAME_SAMPLES + 1);
  localparam int CW = $clog2(2 * CLOCKS_PER_SAMPLE);
  localparam int SW = $clog2(SILENCE_LIMIT + 1);
  localparam int START_PTR = (FRAME_START_INDEX < FRAME_SAMPLES) ? FRAME_START_INDEX : 0;

  localparam logic [AW-1:0] LAST_IDX  = AW'(FRAME_SAMPLES - 1);
  localparam logic [FW-1:0] FULL_CNT  = FW'(FRAME_SAMPLES);
  localparam logic [CW-1:0] CPS       = CW'(CLOCKS_PER_SAMPLE);
  localparam logic [SW-1:0] SIL_LIMIT = SW'(SILENCE_LIMIT);

  state_t              state_r, state_nxt;
  logic [VOL_W-1:0]    vol_r;
  logic                en_r;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                changed_r, changed_nxt;
  logic [SW-1:0]       sil_r, sil_nxt;
  logic                frame_mode_r, frame_mode_nxt;
  logic                neg_r, neg_nxt;
  logic                oor_r, oor_nxt;
  logic                out_valid_r, out_valid_nxt;
  fssg_out_t           out_data_r, out_data_nxt;

  logic                slot_we;
  logic [AW-1:0]       slot_waddr;
  logic [BYTE_W-1:0]   slot_wdata;
  logic [BYTE_W-1:0]   slot_rdata;
  logic                frm_we;
  logic [SAMPLE_W-1:0] frm_wdata;
  logic [SAMPLE_W-1:0] frm_rdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept;
  logic [CW-1:0]       tick_cyc;
  logic [CW-1:0]       acc_sum;
  logic [AW-1:0]       ptr_inc;
  logic [FW-1:0]       fill_inc;
  logic [BYTE_W-1:0]   mag;
  logic [SAMPLE_W-1:0] sample;
  logic [SW-1:0]       sil_inc;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // sound buffer shadow
  fssg_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_SAMPLES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (ptr_r),
    .rdata (slot_rdata)
  );

  // frame store, written at the fill position
  fssg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FRAME_SAMPLES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frm_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (frm_wdata),
    .raddr (in_data.frame_index[AW-1:0]),
    .rdata (frm_rdata)
  );

  // shared divider for sample scaling
  fssg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // small arithmetic helpers
  always_comb begin
    tick_cyc = (32'(in_data.cycle_count) > CLOCKS_PER_SAMPLE) ? CPS : CW'(in_data.cycle_count);
    acc_sum  = acc_r + tick_cyc;
    ptr_inc  = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
    fill_inc = fill_r + 1'b1;
    sil_inc  = sil_r + 1'b1;
    mag      = slot_rdata[BYTE_W-1] ? (slot_rdata - BYTE_MID) : (BYTE_MID - slot_rdata);
    sample   = neg_r ? (MIDPOINT - div_rsp.quotient) : (MIDPOINT + div_rsp.quotient);
  end

  // sequencer: next state, datapath updates and results
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    acc_nxt        = acc_r;
    prev_nxt       = prev_r;
    changed_nxt    = changed_r;
    sil_nxt        = sil_r;
    frame_mode_nxt = frame_mode_r;
    neg_nxt        = neg_r;
    oor_nxt        = oor_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    slot_we        = 1'b0;
    slot_waddr     = in_data.slot_index[AW-1:0];
    slot_wdata     = in_data.slot_byte;
    frm_we         = 1'b0;
    frm_wdata      = MIDPOINT;
    div_req        = '0;

    case (state_r)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_TICK: begin
              if (!en_r || fill_r >= FULL_CNT) begin
                out_valid_nxt = 1'b1;
              end else if (acc_sum >= CPS) begin
                acc_nxt        = acc_sum - CPS;
                frame_mode_nxt = 1'b0;
                state_nxt      = ST_SLOT_RD;
              end else begin
                acc_nxt       = acc_sum;
                out_valid_nxt = 1'b1;
              end
            end
            OP_WRITE: begin
              slot_we       = (32'(in_data.slot_index) < FRAME_SAMPLES);
              out_valid_nxt = 1'b1;
            end
            OP_FRAME: begin
              state_nxt = ST_FRAME_END;
              if (fill_r < FULL_CNT) begin
                if (en_r) begin
                  frame_mode_nxt = 1'b1;
                  state_nxt      = ST_SLOT_RD;
                end else if (sil_r < SIL_LIMIT || fill_r != '0) begin
                  if (prev_r != MIDPOINT) begin
                    changed_nxt = 1'b1;
                  end
                  prev_nxt  = MIDPOINT;
                  state_nxt = ST_MID_FILL;
                end
              end
            end
            OP_READ: begin
              oor_nxt   = (32'(in_data.frame_index) >= FRAME_SAMPLES);
              state_nxt = ST_FRAME_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // slot ram read in flight
      ST_SLOT_RD: begin
        state_nxt = ST_DIV_GO;
      end

      // offset from midpoint goes to the divider
      ST_DIV_GO: begin
        neg_nxt          = !slot_rdata[BYTE_W-1];
        div_req.start    = 1'b1;
        div_req.dividend = {mag, {(SAMPLE_W - BYTE_W){1'b0}}};
        div_req.divisor  = DIV_BASE - {1'b0, vol_r};
        state_nxt        = ST_DIV_WAIT;
      end

      // store the finished sample
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          frm_we    = 1'b1;
          frm_wdata = sample;
          fill_nxt  = fill_inc;
          ptr_nxt   = ptr_inc;
          if (sample != prev_r) begin
            prev_nxt    = sample;
            changed_nxt = 1'b1;
          end
          if (!frame_mode_r) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.sample_valid  = 1'b1;
            out_data_nxt.sample_value  = sample;
            state_nxt                  = ST_IDLE;
          end else if (fill_inc == FULL_CNT) begin
            state_nxt = ST_FRAME_END;
          end else begin
            state_nxt = ST_SLOT_RD;
          end
        end
      end

      // top up with midpoint while disabled
      ST_MID_FILL: begin
        frm_we   = 1'b1;
        fill_nxt = fill_inc;
        ptr_nxt  = ptr_inc;
        if (fill_inc == FULL_CNT) begin
          state_nxt = ST_FRAME_END;
        end
      end

      // silence counting, frame result and restart
      ST_FRAME_END: begin
        if (changed_r) begin
          out_data_nxt.speaker_start = (sil_r >= SIL_LIMIT);
          sil_nxt                    = '0;
        end else if (sil_r < SIL_LIMIT) begin
          sil_nxt                   = sil_inc;
          out_data_nxt.speaker_stop = (sil_inc == SIL_LIMIT);
        end
        out_data_nxt.frame_play   = (sil_nxt < SIL_LIMIT);
        out_data_nxt.frame_length = IDX_W'(fill_r);
        out_valid_nxt             = 1'b1;
        changed_nxt               = 1'b0;
        ptr_nxt                   = AW'(START_PTR);
        fill_nxt                  = '0;
        acc_nxt                   = '0;
        state_nxt                 = ST_IDLE;
      end

      // frame store read-back
      ST_FRAME_RD: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.read_data = oor_r ? '0 : frm_rdata;
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      vol_r       <= '0;
      en_r        <= 1'b0;
      clr_r       <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      acc_r       <= '0;
      prev_r      <= MIDPOINT;
      changed_r   <= 1'b0;
      sil_r       <= SIL_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      acc_r       <= acc_nxt;
      prev_r      <= prev_nxt;
      changed_r   <= changed_nxt;
      sil_r       <= sil_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VOLUME) begin
          vol_r <= cfg_data[VOL_W-1:0];
        end else if (cfg_index == CFG_ENABLE) begin
          en_r <= cfg_data[0];
        end
      end
    end
    frame_mode_r <= frame_mode_nxt;
    neg_r        <= neg_nxt;
    oor_r        <= oor_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_data_r;

endmodule

`default_nettype wire

FILE: tb/frame_sample_sound_generator_top_tb.sv
// self-checking testbench for the frame sample sound generator top level
module frame_sample_sound_generator_top_tb import fssg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS       = FRAME_SAMPLES_DEF;
  localparam int CPS          = CLOCKS_PER_SAMPLE_DEF;
  localparam int SIL_LIM      = SILENCE_LIMIT_DEF;
  localparam int FRAME_START  = FRAME_START_INDEX_DEF;
  localparam int IDLE_PCT     = 18;
  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  fssg_in_t             in_data = '0;
  logic                 out_strobe;
  fssg_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predictor state: buffer shadow, frame store and sequencing counters
  logic [BYTE_W-1:0]   slot_shadow [NSLOTS];
  logic [SAMPLE_W-1:0] frame_shadow [NSLOTS];
  bit                  frame_written [NSLOTS];
  int                  rd_ptr, fill_cnt, cyc_acc, quiet_frames;
  logic [SAMPLE_W-1:0] last_sample;
  bit                  level_changed;
  logic [VOL_W-1:0]    volume;
  bit                  enabled;

  fssg_out_t awaited_results [$];
  bit        no_idle;
  int        sent_count, mismatches, cycle_cnt, cfg_writes;
  int        samples_seen, frames_seen, reads_seen, starts_seen, stops_seen;

  frame_sample_sound_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // one buffer byte becomes the next frame sample, scaled toward the midpoint
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int d, v;
    logic [SAMPLE_W-1:0] s;
    d = 8 - int'(volume);
    v = int'(slot_shadow[rd_ptr]) << 8;
    if (v < 32768) s = SAMPLE_W'(32768 - (32768 - v) / d);
    else s = SAMPLE_W'(32768 + (v - 32768) / d);
    rd_ptr = (rd_ptr == NSLOTS - 1) ? 0 : rd_ptr + 1;
    if (s != last_sample) begin
      last_sample = s;
      level_changed = 1'b1;
    end
    frame_shadow[fill_cnt] = s;
    frame_written[fill_cnt] = 1'b1;
    fill_cnt++;
    return s;
  endfunction

  // expected result of one accepted request, advancing the shadow state
  function automatic fssg_out_t compute_sound_result(fssg_in_t req);
    fssg_out_t r;
    int cyc;
    r = '0;
    case (op_t'(req.opcode))
      OP_TICK: begin
        if (enabled && fill_cnt < NSLOTS) begin
          cyc = (req.cycle_count > CPS) ? CPS : int'(req.cycle_count);
          cyc_acc += cyc;
          if (cyc_acc >= CPS) begin
            cyc_acc -= CPS;
            r.sample_valid = 1'b1;
            r.sample_value = next_sample();
          end
        end
      end
      OP_WRITE: begin
        if (req.slot_index < NSLOTS) slot_shadow[req.slot_index] = req.slot_byte;
      end
      OP_FRAME: begin
        // top up the frame: samples when enabled, midpoint when disabled
        if (fill_cnt < NSLOTS) begin
          if (enabled) begin
            while (fill_cnt < NSLOTS) void'(next_sample());
          end else if (quiet_frames < SIL_LIM || fill_cnt > 0) begin
            if (last_sample != MIDPOINT) level_changed = 1'b1;
            while (fill_cnt < NSLOTS) begin
              frame_shadow[fill_cnt] = MIDPOINT;
              frame_written[fill_cnt] = 1'b1;
              rd_ptr = (rd_ptr == NSLOTS - 1) ? 0 : rd_ptr + 1;
              fill_cnt++;
            end
            last_sample = MIDPOINT;
          end
        end
        // silence counter and speaker events
        if (level_changed) begin
          r.speaker_start = (quiet_frames >= SIL_LIM);
          quiet_frames = 0;
        end else if (quiet_frames < SIL_LIM) begin
          quiet_frames++;
          r.speaker_stop = (quiet_frames == SIL_LIM);
        end
        r.frame_play = (quiet_frames < SIL_LIM);
        r.frame_length = IDX_W'(fill_cnt);
        // restart the frame
        level_changed = 1'b0;
        rd_ptr = (FRAME_START < NSLOTS) ? FRAME_START : 0;
        fill_cnt = 0;
        cyc_acc = 0;
      end
      OP_READ: begin
        if (req.frame_index < NSLOTS) r.read_data = frame_shadow[req.frame_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic fssg_in_t build_request(op_t op, int cyc, int slot, int byt, int fidx);
    fssg_in_t r;
    r.opcode = op;
    r.cycle_count = IDX_W'(cyc);
    r.slot_index = IDX_W'(slot);
    r.slot_byte = BYTE_W'(byt);
    r.frame_index = IDX_W'(fidx);
    return r;
  endfunction

  // random request of one opcode; unused fields carry random bits
  function automatic fssg_in_t random_request(op_t op);
    int cyc, slot, byt, fidx;
    cyc = $urandom_range(0, 511);
    slot = $urandom_range(0, 511);
    byt = $urandom_range(0, 255);
    fidx = $urandom_range(0, 511);
    case (op)
      OP_TICK: begin
        case ($urandom_range(0, 3))
          0, 1: cyc = CPS;
          2: cyc = $urandom_range(CPS, 511);
          default: ;
        endcase
      end
      OP_WRITE: begin
        if ($urandom_range(0, 7) != 0) slot = $urandom_range(0, NSLOTS - 1);
      end
      OP_READ: begin
        // only entries already written, or ones past the end of the store
        if (!frame_written[0] || $urandom_range(0, 4) == 0) begin
          fidx = $urandom_range(NSLOTS, 511);
        end else begin
          do fidx = $urandom_range(0, NSLOTS - 1); while (!frame_written[fidx]);
        end
      end
      default: ;
    endcase
    return build_request(op, cyc, slot, byt, fidx);
  endfunction

  function automatic op_t noise_op();
    case ($urandom_range(0, 2))
      0: return OP_TICK;
      1: return OP_WRITE;
      default: return OP_READ;
    endcase
  endfunction

  // send one request, predicting its result at the accepting edge
  task automatic send_request(fssg_in_t req);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    awaited_results.push_back(compute_sound_result(req));
    sent_count++;
  endtask

  // hold off requests until every awaited result has come and the block is quiet
  task automatic wait_for_results(int settle);
    start <= 1'b0;
    while (awaited_results.size() != 0 || busy) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VOLUME) volume = value[VOL_W-1:0];
    else if (idx == CFG_ENABLE) enabled = value[0];
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // both registers, with random bits above the used ones
  task automatic set_config(int vol, bit en);
    write_config(CFG_VOLUME, {(CFG_DAT_W-VOL_W)'($urandom_range(0, 31)), VOL_W'(vol)});
    write_config(CFG_ENABLE, {(CFG_DAT_W-1)'($urandom_range(0, 127)), en});
  endtask

  // extremes of the fields, every opcode and the corner behaviors
  task automatic test_directed();
    wait_for_results(SETTLE_CYCLES);
    // read past the store, tick and frame end while disabled and silent
    send_request(build_request(OP_READ, 0, 0, 0, 511));
    send_request(build_request(OP_TICK, CPS, 0, 0, 0));
    send_request(build_request(OP_FRAME, 0, 0, 0, 0));
    wait_for_results(SETTLE_CYCLES);
    set_config(7, 1'b1);
    // buffer extremes and an out of range slot write
    send_request(build_request(OP_WRITE, 0, 0, 8'hFF, 0));
    send_request(build_request(OP_WRITE, 0, 1, 8'h00, 0));
    send_request(build_request(OP_WRITE, 0, FRAME_START, 8'h80, 0));
    send_request(build_request(OP_WRITE, 0, NSLOTS - 1, 8'h7F, 0));
    send_request(build_request(OP_WRITE, 0, 511, 8'hAA, 0));
    // zero, oversized and split tick counts
    send_request(build_request(OP_TICK, 0, 0, 0, 0));
    send_request(build_request(OP_TICK, 511, 0, 0, 0));
    send_request(build_request(OP_TICK, CPS - 1, 0, 0, 0));
    send_request(build_request(OP_TICK, 1, 0, 0, 0));
    // enabled frame end tops up with samples
    send_request(build_request(OP_FRAME, 0, 0, 0, 0));
    send_request(build_request(OP_READ, 0, 0, 0, 0));
    send_request(build_request(OP_READ, 0, 0, 0, NSLOTS - 1));
    send_request(build_request(OP_READ, 0, 0, 0, 1));
    wait_for_results(SETTLE_CYCLES);
    set_config(0, 1'b1);
    send_request(build_request(OP_TICK, CPS, 0, 0, 0));
    send_request(build_request(OP_TICK, CPS, 0, 0, 0));
    // disable with a partial frame: midpoint fill
    wait_for_results(SETTLE_CYCLES);
    write_config(CFG_ENABLE, {7'h7F, 1'b0});
    send_request(build_request(OP_FRAME, 0, 0, 0, 0));
    send_request(build_request(OP_READ, 0, 0, 0, 2));
    send_request(build_request(OP_READ, 0, 0, 0, NSLOTS - 1));
    send_request(build_request(OP_READ, 0, 0, 0, NSLOTS));
  endtask

  // disabled frames until the speaker stops, then sound resumes
  task automatic test_silence_run();
    int guard;
    wait_for_results(SETTLE_CYCLES);
    set_config($urandom_range(0, 7), 1'b0);
    guard = 0;
    while (quiet_frames < SIL_LIM && guard < 3 * SIL_LIM) begin
      repeat ($urandom_range(0, 2)) send_request(random_request(noise_op()));
      send_request(random_request(OP_FRAME));
      guard++;
    end
    // fully silent and empty: nothing to fill
    repeat (3) send_request(random_request(OP_FRAME));
    wait_for_results(SETTLE_CYCLES);
    set_config($urandom_range(0, 7), 1'b1);
    repeat (12) send_request(random_request($urandom_range(0, 1) ? OP_TICK : OP_WRITE));
    send_request(random_request(OP_FRAME));
  endtask

  // ticks past a full frame, with no idle gaps
  task automatic test_full_frame();
    wait_for_results(SETTLE_CYCLES);
    set_config($urandom_range(1, 6), 1'b1);
    no_idle = 1'b1;
    while (fill_cnt < NSLOTS) begin
      if ($urandom_range(0, 15) == 0) send_request(random_request(OP_READ));
      send_request(random_request(OP_TICK));
    end
    repeat (6) send_request(random_request(OP_TICK));
    send_request(random_request(OP_FRAME));
    no_idle = 1'b0;
  endtask

  // frames of random writes, ticks and reads closed by a frame end
  task automatic test_random_frames();
    int frame_items, k, pick, vol;
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_for_results(SETTLE_CYCLES);
        case ($urandom_range(0, 3))
          0: vol = 0;
          1: vol = 7;
          default: vol = $urandom_range(0, 7);
        endcase
        set_config(vol, $urandom_range(0, 9) != 0);
      end
      frame_items = $urandom_range(4, 40);
      for (k = 0; k < frame_items; k++) begin
        // occasionally flip enable mid-frame
        if (k == frame_items / 2 && $urandom_range(0, 5) == 0) begin
          wait_for_results(SETTLE_CYCLES);
          write_config(CFG_ENABLE, {(CFG_DAT_W-1)'($urandom_range(0, 127)), !enabled});
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) send_request(random_request(OP_TICK));
        else if (pick < 75) send_request(random_request(OP_WRITE));
        else if (pick < 98) send_request(random_request(OP_READ));
        else send_request(random_request(OP_FRAME));
      end
      send_request(random_request(OP_FRAME));
    end
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each strobed result with the oldest awaited one
  always @(posedge clk) begin : check_results
    fssg_out_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("sample_valid", 16'(want.sample_valid), 16'(out_data.sample_valid));
        check_field("sample_value", want.sample_value, out_data.sample_value);
        check_field("frame_play", 16'(want.frame_play), 16'(out_data.frame_play));
        check_field("speaker_start", 16'(want.speaker_start), 16'(out_data.speaker_start));
        check_field("speaker_stop", 16'(want.speaker_stop), 16'(out_data.speaker_stop));
        check_field("frame_length", 16'(want.frame_length), 16'(out_data.frame_length));
        check_field("read_data", want.read_data, out_data.read_data);
        samples_seen += int'(want.sample_valid);
        starts_seen += int'(want.speaker_start);
        stops_seen += int'(want.speaker_stop);
        if (want.frame_length != 0) frames_seen++;
        if (want.read_data != 0) reads_seen++;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < NSLOTS; i++) begin
      slot_shadow[i] = '0;
      frame_shadow[i] = '0;
      frame_written[i] = 1'b0;
    end
    rd_ptr = 0;
    fill_cnt = 0;
    cyc_acc = 0;
    quiet_frames = SIL_LIM;
    last_sample = MIDPOINT;
    level_changed = 1'b0;
    volume = '0;
    enabled = 1'b0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_silence_run();
    test_full_frame();
    test_random_frames();
    wait_for_results(40);

    $display("%0d requests, %0d config writes: %0d samples, %0d filled frames, %0d nonzero reads",
             sent_count, cfg_writes, samples_seen, frames_seen, reads_seen);
    $display("speaker start events %0d, speaker stop events %0d, mismatches %0d",
             starts_seen, stops_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
